// File: rtl/core/tgb_pkg.sv
package tgb_pkg;

    localparam int COORD_W = 32;
    localparam int TAG_W   = 24;
    localparam int CELL_W  = 16;
    localparam int ZS_W    = 24;
    localparam int GRID_W  = 9;

    localparam logic [ZS_W-1:0]   ZONE_SIZE_RESET = 24'd128000;
    localparam logic [GRID_W-1:0] GRID_RESET      = 9'd1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ZONE_SIZE  = 2'd0,
        REG_GRID_WIDTH = 2'd1,
        REG_GRID_DEPTH = 2'd2
    } reg_index_t;

    // Which bounding-box bound goes through the divider.
    typedef enum logic [1:0] {
        SEL_X_MIN = 2'd0,
        SEL_X_MAX = 2'd1,
        SEL_Z_MIN = 2'd2,
        SEL_Z_MAX = 2'd3
    } sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLOAD,
        ST_DITER,
        ST_CLAMP,
        ST_MULT,
        ST_START,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic clamp;
        logic mult;
        logic start;
        logic emit;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic div_skip;
        logic div_last;
        logic empty;
        logic out_free;
        logic cell_last;
    } status_t;

endpackage

// File: rtl/core/triangle_grid_binner_unit.sv
// Triangle grid binner. One transfer on the s_ channel carries a triangle
// (three X/Z vertices and a polygon index); the m_ channel then returns one
// transfer per grid cell covered by the triangle's bounding box, x cells in
// the outer order and z cells in the inner order, with m_tlast on the final
// pair and m_tuser set on that pair when the cell cap cut the list short.
// A triangle that covers no cell in the grid returns nothing.
// Each bound is divided by the zone size in a shared restoring divider: a
// load step sets it up, then it produces one quotient bit per cycle (9 bits
// with the default grid limits) unless the bound is negative or its quotient
// would overflow the quotient width. A triangle passes through the accept
// state, the divider, the clamp, multiply and start states, and then emits
// one pair per cycle while the output register is free to take it.
// The next triangle is taken as soon as the last pair sits in the output
// register, even while the receiver has not yet taken it. When m_tready is
// low the output register holds its pair and the cell walk waits.
// Reset (aresetn low, synchronous) empties the output register, returns the
// controller to idle and loads the register defaults: zone size 500.0,
// grid width and depth of one cell. The registers are read live by the
// divider and the cell walk, so they must be written only while idle.
module triangle_grid_binner_unit #(
    parameter int MAX_GRID_X = 256,
    parameter int MAX_GRID_Z = 256,
    parameter int MAX_CELLS  = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    // Triangle input channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: a_x[31:0], a_z, b_x, b_z, c_x, c_z, poly_id[23:0].
    input  logic [215:0] s_tdata,
    // Cell/polygon pair output channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: cell_index[15:0], poly_tag[23:0].
    output logic [39:0]  m_tdata,
    output logic         m_tlast,
    // m_tuser: truncated.
    output logic         m_tuser
);

    logic [tgb_pkg::ZS_W-1:0]   zone_size_reg, zone_size_next;
    logic [tgb_pkg::GRID_W-1:0] grid_width_reg, grid_width_next;
    logic [tgb_pkg::GRID_W-1:0] grid_depth_reg, grid_depth_next;

    tgb_pkg::cmd_t    cmd;
    tgb_pkg::status_t status;

    logic [tgb_pkg::CELL_W-1:0] cell_index;
    logic [tgb_pkg::TAG_W-1:0]  poly_tag;

    // Register writes. An index with no register behind it is dropped.
    always_comb begin
        zone_size_next  = zone_size_reg;
        grid_width_next = grid_width_reg;
        grid_depth_next = grid_depth_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                tgb_pkg::REG_ZONE_SIZE:  zone_size_next  = cfg_wdata;
                tgb_pkg::REG_GRID_WIDTH: grid_width_next = cfg_wdata[tgb_pkg::GRID_W-1:0];
                tgb_pkg::REG_GRID_DEPTH: grid_depth_next = cfg_wdata[tgb_pkg::GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_size_reg  <= tgb_pkg::ZONE_SIZE_RESET;
            grid_width_reg <= tgb_pkg::GRID_RESET;
            grid_depth_reg <= tgb_pkg::GRID_RESET;
        end else begin
            zone_size_reg  <= zone_size_next;
            grid_width_reg <= grid_width_next;
            grid_depth_reg <= grid_depth_next;
        end
    end

    // The controller sequences the divider and the cell walk.
    tgb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the bounding box, the divider, the cell counters and
    // the output register.
    tgb_dp #(
        .MAX_GRID_X (MAX_GRID_X),
        .MAX_GRID_Z (MAX_GRID_Z),
        .MAX_CELLS  (MAX_CELLS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .a_x        (s_tdata[31:0]),
        .a_z        (s_tdata[63:32]),
        .b_x        (s_tdata[95:64]),
        .b_z        (s_tdata[127:96]),
        .c_x        (s_tdata[159:128]),
        .c_z        (s_tdata[191:160]),
        .poly_id    (s_tdata[215:192]),
        .zone_size  (zone_size_reg),
        .grid_width (grid_width_reg),
        .grid_depth (grid_depth_reg),
        .cell_index (cell_index),
        .poly_tag   (poly_tag),
        .last       (m_tlast),
        .truncated  (m_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {poly_tag, cell_index};

endmodule

// File: rtl/core/tgb_ctrl.sv
module tgb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               in_ready,
    input  tgb_pkg::status_t   status,
    output tgb_pkg::cmd_t      cmd
);

    tgb_pkg::state_t state_reg, state_next;
    tgb_pkg::sel_t   sel_reg, sel_next;
    tgb_pkg::sel_t   sel_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tgb_pkg::ST_IDLE;
            sel_reg   <= tgb_pkg::SEL_X_MIN;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        unique case (sel_reg)
            tgb_pkg::SEL_X_MIN: sel_inc = tgb_pkg::SEL_X_MAX;
            tgb_pkg::SEL_X_MAX: sel_inc = tgb_pkg::SEL_Z_MIN;
            tgb_pkg::SEL_Z_MIN: sel_inc = tgb_pkg::SEL_Z_MAX;
            default:            sel_inc = tgb_pkg::SEL_X_MIN;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.sel     = sel_reg;
        unique case (state_reg)
            tgb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    sel_next    = tgb_pkg::SEL_X_MIN;
                    state_next  = tgb_pkg::ST_DLOAD;
                end
            end
            tgb_pkg::ST_DLOAD: begin
                cmd.load = 1'b1;
                if (status.div_skip) begin
                    if (sel_reg == tgb_pkg::SEL_Z_MAX) begin
                        state_next = tgb_pkg::ST_CLAMP;
                    end else begin
                        sel_next = sel_inc;
                    end
                end else begin
                    state_next = tgb_pkg::ST_DITER;
                end
            end
            tgb_pkg::ST_DITER: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    if (sel_reg == tgb_pkg::SEL_Z_MAX) begin
                        state_next = tgb_pkg::ST_CLAMP;
                    end else begin
                        sel_next   = sel_inc;
                        state_next = tgb_pkg::ST_DLOAD;
                    end
                end
            end
            tgb_pkg::ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = status.empty ? tgb_pkg::ST_IDLE : tgb_pkg::ST_MULT;
            end
            tgb_pkg::ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = tgb_pkg::ST_START;
            end
            tgb_pkg::ST_START: begin
                cmd.start  = 1'b1;
                state_next = tgb_pkg::ST_EMIT;
            end
            tgb_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.cell_last) begin
                        state_next = tgb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tgb_pkg::ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("cell emitted while the output register was occupied");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.cell_last) |=> (state_reg == tgb_pkg::ST_IDLE))
        else $error("controller did not return to idle after the final cell");

    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == tgb_pkg::ST_DLOAD && sel_reg == tgb_pkg::SEL_X_MIN))
        else $error("division sequence did not start at the lower X bound");

endmodule

// File: rtl/core/tgb_dp.sv
module tgb_dp #(
    parameter int MAX_GRID_X = 256,
    parameter int MAX_GRID_Z = 256,
    parameter int MAX_CELLS  = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tgb_pkg::cmd_t                         cmd,
    output tgb_pkg::status_t                      status,
    input  logic signed [tgb_pkg::COORD_W-1:0]    a_x,
    input  logic signed [tgb_pkg::COORD_W-1:0]    a_z,
    input  logic signed [tgb_pkg::COORD_W-1:0]    b_x,
    input  logic signed [tgb_pkg::COORD_W-1:0]    b_z,
    input  logic signed [tgb_pkg::COORD_W-1:0]    c_x,
    input  logic signed [tgb_pkg::COORD_W-1:0]    c_z,
    input  logic        [tgb_pkg::TAG_W-1:0]      poly_id,
    input  logic        [tgb_pkg::ZS_W-1:0]       zone_size,
    input  logic        [tgb_pkg::GRID_W-1:0]     grid_width,
    input  logic        [tgb_pkg::GRID_W-1:0]     grid_depth,
    output logic        [tgb_pkg::CELL_W-1:0]     cell_index,
    output logic        [tgb_pkg::TAG_W-1:0]      poly_tag,
    output logic                                  last,
    output logic                                  truncated,
    output logic                                  out_valid,
    input  logic                                  out_ready
);

    localparam int MAXG = (MAX_GRID_X > MAX_GRID_Z) ? MAX_GRID_X : MAX_GRID_Z;
    localparam int QW   = $clog2(MAXG + 1);
    localparam int CW   = (QW > tgb_pkg::GRID_W) ? QW : tgb_pkg::GRID_W;
    localparam int IW   = $clog2(QW + 1);
    localparam int NW   = $clog2(MAX_CELLS + 1);
    localparam int PW   = 2 * QW;
    localparam int CO   = tgb_pkg::COORD_W;
    localparam int ZW   = tgb_pkg::ZS_W;
    localparam int XW   = tgb_pkg::CELL_W;

    // Bounding box.
    logic signed [CO-1:0] xmin_reg, xmax_reg, zmin_reg, zmax_reg;
    logic signed [CO-1:0] xmin_next, xmax_next, zmin_next, zmax_next;
    logic [tgb_pkg::TAG_W-1:0] tag_reg, tag_next;

    // Divider.
    logic [ZW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    // Cell ranges.
    logic [QW-1:0] x1_reg, x2_reg, z1_reg, z2_reg;
    logic [QW-1:0] x1_next, x2_next, z1_next, z2_next;
    logic          x2neg_reg, z2neg_reg, x2neg_next, z2neg_next;
    logic [QW-1:0] x2c_reg, z2c_reg, x2c_next, z2c_next;

    // Cell walk.
    logic [XW-1:0] prod_reg, prod_next;
    logic [XW-1:0] col_reg, col_next;
    logic [XW-1:0] idx_reg, idx_next;
    logic [QW-1:0] xx_reg, zz_reg, xx_next, zz_next;
    logic [NW-1:0] n_reg, n_next;

    // Output register.
    logic [XW-1:0]             cell_index_reg, cell_index_next;
    logic [tgb_pkg::TAG_W-1:0] poly_tag_reg, poly_tag_next;
    logic                      last_reg, last_next;
    logic                      truncated_reg, truncated_next;
    logic                      out_valid_reg, out_valid_next;

    // Combinational terms.
    logic signed [CO-1:0] ax_lo, ax_hi, az_lo, az_hi;
    logic [ZW-1:0]        zs;
    logic signed [CO-1:0] v;
    logic [CO:0]          neg_sum;
    logic                 q_neg;
    logic [CO-2:0]        v_high;
    logic                 v_sat;
    logic                 skip;
    logic [QW-1:0]        load_q;
    logic [ZW:0]          trial, trial_diff;
    logic                 trial_ge;
    logic [QW-1:0]        q_step;
    logic                 div_last;
    logic                 q_write;
    logic [QW-1:0]        q_value;
    logic [CW-1:0]        gw_ext, gd_ext;
    logic [QW-1:0]        gw_eff, gd_eff, gw_m1, gd_m1;
    logic [QW-1:0]        x2_clamp, z2_clamp;
    logic [PW-1:0]        prod_full;
    logic                 rect_last, cap_last, cell_last, out_free;

    assign zs = (zone_size == '0) ? ZW'(1) : zone_size;

    always_comb begin
        ax_lo = (b_x < a_x) ? b_x : a_x;
        ax_lo = (c_x < ax_lo) ? c_x : ax_lo;
        ax_hi = (b_x > a_x) ? b_x : a_x;
        ax_hi = (c_x > ax_hi) ? c_x : ax_hi;
        az_lo = (b_z < a_z) ? b_z : a_z;
        az_lo = (c_z < az_lo) ? c_z : az_lo;
        az_hi = (b_z > a_z) ? b_z : a_z;
        az_hi = (c_z > az_hi) ? c_z : az_hi;
    end

    // A negative bound gives quotient zero; an upper bound at or below minus the
    // zone size is flagged negative. A positive bound whose quotient would not
    // fit in QW bits saturates to all ones, which lies beyond any grid edge.
    always_comb begin
        unique case (cmd.sel)
            tgb_pkg::SEL_X_MIN: v = xmin_reg;
            tgb_pkg::SEL_X_MAX: v = xmax_reg;
            tgb_pkg::SEL_Z_MIN: v = zmin_reg;
            default:            v = zmax_reg;
        endcase
        neg_sum = {v[CO-1], v} + {{(CO+1-ZW){1'b0}}, zs};
        q_neg   = neg_sum[CO] || (neg_sum == '0);
        v_high  = v[CO-2:0] >> QW;
        v_sat   = v_high >= (CO-1)'(zs);
        skip    = v[CO-1] || v_sat;
        load_q  = v[CO-1] ? '0 : '1;
    end

    always_comb begin
        trial      = {rem_reg, sh_reg[QW-1]};
        trial_diff = trial - {1'b0, zs};
        trial_ge   = trial >= {1'b0, zs};
        q_step     = QW'({q_reg, trial_ge});
        div_last   = (cnt_reg == '0);
        q_write    = (cmd.load && skip) || (cmd.step && div_last);
        q_value    = cmd.load ? load_q : q_step;
    end

    always_comb begin
        gw_ext   = CW'(grid_width);
        gd_ext   = CW'(grid_depth);
        gw_eff   = QW'((gw_ext > CW'(MAX_GRID_X)) ? CW'(MAX_GRID_X) : gw_ext);
        gd_eff   = QW'((gd_ext > CW'(MAX_GRID_Z)) ? CW'(MAX_GRID_Z) : gd_ext);
        gw_m1    = gw_eff - QW'(1);
        gd_m1    = gd_eff - QW'(1);
        x2_clamp = (x2_reg > gw_m1) ? gw_m1 : x2_reg;
        z2_clamp = (z2_reg > gd_m1) ? gd_m1 : z2_reg;
    end

    assign prod_full = PW'(z1_reg) * PW'(gw_eff);

    always_comb begin
        rect_last = (xx_reg == x2c_reg) && (zz_reg == z2c_reg);
        cap_last  = (n_reg == NW'(MAX_CELLS - 1));
        cell_last = rect_last || cap_last;
        out_free  = !out_valid_reg || out_ready;
    end

    always_comb begin
        status.div_skip  = skip;
        status.div_last  = div_last;
        status.empty     = (gw_eff == '0) || (gd_eff == '0) || x2neg_reg || z2neg_reg
                           || (x1_reg > x2_clamp) || (z1_reg > z2_clamp);
        status.out_free  = out_free;
        status.cell_last = cell_last;
    end

    always_comb begin
        xmin_next  = xmin_reg;
        xmax_next  = xmax_reg;
        zmin_next  = zmin_reg;
        zmax_next  = zmax_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        z1_next    = z1_reg;
        z2_next    = z2_reg;
        x2neg_next = x2neg_reg;
        z2neg_next = z2neg_reg;
        x2c_next   = x2c_reg;
        z2c_next   = z2c_reg;
        prod_next  = prod_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        xx_next    = xx_reg;
        zz_next    = zz_reg;
        n_next     = n_reg;
        cell_index_next = cell_index_reg;
        poly_tag_next   = poly_tag_reg;
        last_next       = last_reg;
        truncated_next  = truncated_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.capture) begin
            xmin_next = ax_lo;
            xmax_next = ax_hi;
            zmin_next = az_lo;
            zmax_next = az_hi;
            tag_next  = poly_id;
        end

        if (cmd.load) begin
            rem_next = ZW'(v_high);
            sh_next  = v[QW-1:0];
            q_next   = '0;
            cnt_next = IW'(QW - 1);
            if (cmd.sel == tgb_pkg::SEL_X_MAX) begin
                x2neg_next = v[CO-1] && q_neg;
            end
            if (cmd.sel == tgb_pkg::SEL_Z_MAX) begin
                z2neg_next = v[CO-1] && q_neg;
            end
        end

        if (cmd.step) begin
            rem_next = trial_ge ? trial_diff[ZW-1:0] : trial[ZW-1:0];
            sh_next  = sh_reg << 1;
            q_next   = q_step;
            cnt_next = cnt_reg - IW'(1);
        end

        if (q_write) begin
            unique case (cmd.sel)
                tgb_pkg::SEL_X_MIN: x1_next = q_value;
                tgb_pkg::SEL_X_MAX: x2_next = q_value;
                tgb_pkg::SEL_Z_MIN: z1_next = q_value;
                default:            z2_next = q_value;
            endcase
        end

        if (cmd.clamp) begin
            x2c_next = x2_clamp;
            z2c_next = z2_clamp;
        end

        if (cmd.mult) begin
            prod_next = XW'(prod_full);
        end

        if (cmd.start) begin
            col_next = prod_reg + XW'(x1_reg);
            idx_next = prod_reg + XW'(x1_reg);
            xx_next  = x1_reg;
            zz_next  = z1_reg;
            n_next   = '0;
        end

        if (cmd.emit) begin
            cell_index_next = idx_reg;
            poly_tag_next   = tag_reg;
            last_next       = cell_last;
            truncated_next  = cap_last && !rect_last;
            out_valid_next  = 1'b1;
            n_next          = n_reg + NW'(1);
            if (zz_reg == z2c_reg) begin
                zz_next  = z1_reg;
                xx_next  = xx_reg + QW'(1);
                col_next = col_reg + XW'(1);
                idx_next = col_reg + XW'(1);
            end else begin
                zz_next  = zz_reg + QW'(1);
                idx_next = idx_reg + XW'(gw_eff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        xmin_reg  <= xmin_next;
        xmax_reg  <= xmax_next;
        zmin_reg  <= zmin_next;
        zmax_reg  <= zmax_next;
        tag_reg   <= tag_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        z1_reg    <= z1_next;
        z2_reg    <= z2_next;
        x2neg_reg <= x2neg_next;
        z2neg_reg <= z2neg_next;
        x2c_reg   <= x2c_next;
        z2c_reg   <= z2c_next;
        prod_reg  <= prod_next;
        col_reg   <= col_next;
        idx_reg   <= idx_next;
        xx_reg    <= xx_next;
        zz_reg    <= zz_next;
        n_reg     <= n_next;
        cell_index_reg <= cell_index_next;
        poly_tag_reg   <= poly_tag_next;
        last_reg       <= last_next;
        truncated_reg  <= truncated_next;
    end

    assign cell_index = cell_index_reg;
    assign poly_tag   = poly_tag_reg;
    assign last       = last_reg;
    assign truncated  = truncated_reg;
    assign out_valid  = out_valid_reg;

    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && truncated_reg) |-> last_reg)
        else $error("truncation flag set on a pair that is not the final one");

endmodule
